/* rtl/core/ptt_pkg.sv */
// Shared types and constants for the periodic timer table.
package ptt_pkg;

    localparam int MaxTimers   = 16;
    localparam int IdWidth     = 32;
    localparam int IvlWidth    = 24;
    localparam int PulseWidth  = 10;
    localparam int QueueDepth  = 2;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_KILL = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    localparam logic [PulseWidth-1:0] PulseReset = 10'd10;

    typedef struct packed {
        logic [1:0]          op;
        logic [IdWidth-1:0]  id;
        logic [IvlWidth-1:0] period;
    } t_cmd;

    typedef struct packed {
        logic [IdWidth-1:0]  id;
        logic [IvlWidth-1:0] period;
        logic [IvlWidth-1:0] phase;
    } t_entry;

endpackage

/* rtl/core/periodic_timer_table_top.sv */
// Top level of the periodic timer table.
//
//  channel   dir  tuser       tdata                              tlast
//  s_axis    in   op[1:0]     timer_id[31:0] interval_ms[55:32]  -
//  m_axis    out  kind[0]     status[1:0] fired_id[33:2]         last
//  cfg       in   -           pulse_ms[9:0] on i_cfg_we          -
//
// A set is divided in the front divider and then searches the table for its
// identifier. A kill searches the table and moves the later entries up.
// A tick walks every table entry.
// The back end handles one request at a time; a two-deep queue lets the
// front accept and divide the next one meanwhile. Reset is synchronous.
// Table contents are not cleared; only the entry count is.
module periodic_timer_table_top #(
    parameter int MaxTimers = ptt_pkg::MaxTimers
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // timer_id[31:0], interval_ms[55:32]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // status[1:0], fired_id[33:2], zeros
    output logic [0:0]  m_axis_tuser,  // kind[0]
    output logic        m_axis_tlast
);
    logic [ptt_pkg::PulseWidth-1:0] r_pulse;
    logic                           w_push, w_full, w_pop, w_empty;
    ptt_pkg::t_cmd                  w_cmd_in, w_cmd_out;
    logic [1:0]                     w_status;
    logic [ptt_pkg::IdWidth-1:0]    w_id;
    logic                           w_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse <= ptt_pkg::PulseReset;
        end else if (i_cfg_we) begin
            r_pulse <= i_cfg_wdata;
        end
    end

    ptt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_id       (s_axis_tdata[31:0]),
        .i_interval (s_axis_tdata[55:32]),
        .i_pulse    (r_pulse),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in),
        .i_full     (w_full)
    );

    ptt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    ptt_back #(.MaxTimers(MaxTimers)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_cmd    (w_cmd_out),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_kind   (w_kind),
        .o_status (w_status),
        .o_id     (w_id),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, w_id, w_status};
    assign m_axis_tuser = w_kind;

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_kind == ptt_pkg::KIND_STATUS) |-> m_axis_tlast)
        else $error("status result without last");
    a_status_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_kind == ptt_pkg::KIND_STATUS) |-> (w_id == '0))
        else $error("status result carries an identifier");
    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_kind == ptt_pkg::KIND_FIRED) |-> (w_status == ptt_pkg::ST_OK))
        else $error("fired result with nonzero status");
endmodule

/* rtl/core/ptt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ptt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/ptt_front.sv */
// Front end: accepts requests and turns a set interval into a period.
module ptt_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_op,
    input  logic [ptt_pkg::IdWidth-1:0]    i_id,
    input  logic [ptt_pkg::IvlWidth-1:0]   i_interval,
    input  logic [ptt_pkg::PulseWidth-1:0] i_pulse,
    output logic                           o_push,
    output ptt_pkg::t_cmd                  o_cmd,
    input  logic                           i_full
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam logic [4:0] LastStep = 5'(ptt_pkg::IvlWidth - 1);

    logic [1:0]                     r_state, n_state;
    logic [4:0]                     r_step, n_step;
    logic [1:0]                     r_op, n_op;
    logic [ptt_pkg::IdWidth-1:0]    r_id, n_id;
    logic [ptt_pkg::IvlWidth-1:0]   r_num, n_num;
    logic [ptt_pkg::PulseWidth-1:0] r_rem, n_rem;
    logic [ptt_pkg::PulseWidth-1:0] r_div, n_div;
    logic [ptt_pkg::PulseWidth:0]   w_sh;
    logic [ptt_pkg::PulseWidth:0]   w_diff;
    logic                           w_ge;

    assign w_sh   = {r_rem, r_num[ptt_pkg::IvlWidth-1]};
    assign w_ge   = w_sh >= {1'b0, r_div};
    assign w_diff = w_sh - {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_op    = r_op;
        n_id    = r_id;
        n_num   = r_num;
        n_rem   = r_rem;
        n_div   = r_div;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_op   = i_op;
                    n_id   = i_id;
                    n_num  = i_interval;
                    n_rem  = '0;
                    n_step = '0;
                    n_div  = (i_pulse == '0) ? ptt_pkg::PulseWidth'(1) : i_pulse;
                    n_state = (i_op == ptt_pkg::OP_SET) ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                // One quotient bit per cycle, restoring division.
                n_rem = w_ge ? w_diff[ptt_pkg::PulseWidth-1:0]
                             : w_sh[ptt_pkg::PulseWidth-1:0];
                n_num = {r_num[ptt_pkg::IvlWidth-2:0], w_ge};
                n_step = r_step + 5'd1;
                if (r_step == LastStep) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_step <= n_step;
        r_op   <= n_op;
        r_id   <= n_id;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_ready      = (r_state == F_IDLE);
    assign o_push       = (r_state == F_PUSH) && !i_full;
    assign o_cmd.op     = r_op;
    assign o_cmd.id     = r_id;
    assign o_cmd.period = (r_num == '0) ? ptt_pkg::IvlWidth'(1) : r_num;
endmodule

/* rtl/core/ptt_queue.sv */
// Short command queue between the front end and the table engine.
module ptt_queue #(
    parameter int Depth = ptt_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ptt_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ptt_pkg::t_cmd o_cmd
);
    localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    ptt_pkg::t_cmd r_slot [Depth];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= bump(r_wp);
            end
            if (i_pop) begin
                r_rp <= bump(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == CW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slot[r_rp];
endmodule

/* rtl/core/ptt_back.sv */
// Table engine: search, append, remove and tick over the timer RAM.
module ptt_back #(
    parameter int MaxTimers = ptt_pkg::MaxTimers
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  ptt_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_kind,
    output logic [1:0]                  o_status,
    output logic [ptt_pkg::IdWidth-1:0] o_id,
    output logic                        o_last
);
    localparam int AW = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;
    localparam int CW = $clog2(MaxTimers + 1);
    localparam int EW = $bits(ptt_pkg::t_entry);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_SRD  = 3'd1;
    localparam logic [2:0] B_SCHK = 3'd2;
    localparam logic [2:0] B_SHRD = 3'd3;
    localparam logic [2:0] B_SHWR = 3'd4;
    localparam logic [2:0] B_TRD  = 3'd5;
    localparam logic [2:0] B_TCHK = 3'd6;

    logic [2:0]                  r_state, n_state;
    ptt_pkg::t_cmd               r_cmd, n_cmd;
    logic [CW-1:0]               r_idx, n_idx;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_pend, n_pend;
    logic [ptt_pkg::IdWidth-1:0] r_pend_id, n_pend_id;
    logic                        r_ovalid, n_ovalid;
    logic                        r_okind, n_okind;
    logic [1:0]                  r_ostatus, n_ostatus;
    logic [ptt_pkg::IdWidth-1:0] r_oid, n_oid;
    logic                        r_olast, n_olast;

    logic                        w_we;
    logic [AW-1:0]               w_waddr, w_raddr;
    ptt_pkg::t_entry             w_wdata, w_rdata;
    logic [CW-1:0]               w_next;
    logic                        w_can;
    logic [ptt_pkg::IvlWidth-1:0] w_ph;

    assign w_next  = r_idx + CW'(1);
    assign w_can   = !r_ovalid || i_ready;
    assign w_ph    = w_rdata.phase + ptt_pkg::IvlWidth'(1);
    assign w_raddr = (r_state == B_SHRD || r_state == B_SHWR) ? w_next[AW-1:0]
                                                              : r_idx[AW-1:0];

    ptt_ram #(.Width(EW), .Depth(MaxTimers)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_count   = r_count;
        n_pend    = r_pend;
        n_pend_id = r_pend_id;
        n_ovalid  = r_ovalid && !i_ready;
        n_okind   = r_okind;
        n_ostatus = r_ostatus;
        n_oid     = r_oid;
        n_olast   = r_olast;
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_idx[AW-1:0];
        w_wdata   = '{id: r_cmd.id, period: r_cmd.period, phase: '0};
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_idx = '0;
                    n_pend = 1'b0;
                    if (i_cmd.op == ptt_pkg::OP_SET || i_cmd.op == ptt_pkg::OP_KILL) begin
                        n_state = B_SRD;
                    end else if (i_cmd.op == ptt_pkg::OP_TICK) begin
                        n_state = B_TRD;
                    end
                end
            end
            B_SRD: begin
                if (r_idx < r_count) begin
                    n_state = B_SCHK;
                end else if (w_can) begin
                    // Identifier absent: append on set if there is room, else report full; report on kill.
                    n_ovalid  = 1'b1;
                    n_okind   = ptt_pkg::KIND_STATUS;
                    n_oid     = '0;
                    n_olast   = 1'b1;
                    n_state   = B_IDLE;
                    if (r_cmd.op == ptt_pkg::OP_KILL) begin
                        n_ostatus = ptt_pkg::ST_NOT_FOUND;
                    end else if (r_count < CW'(MaxTimers)) begin
                        n_ostatus = ptt_pkg::ST_OK;
                        w_we      = 1'b1;
                        w_waddr   = r_count[AW-1:0];
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_ostatus = ptt_pkg::ST_FULL;
                    end
                end
            end
            B_SCHK: begin
                if (w_rdata.id != r_cmd.id) begin
                    n_idx   = w_next;
                    n_state = B_SRD;
                end else if (r_cmd.op == ptt_pkg::OP_KILL) begin
                    n_state = B_SHRD;
                end else if (w_can) begin
                    w_we      = 1'b1;
                    n_ovalid  = 1'b1;
                    n_okind   = ptt_pkg::KIND_STATUS;
                    n_ostatus = ptt_pkg::ST_OK;
                    n_oid     = '0;
                    n_olast   = 1'b1;
                    n_state   = B_IDLE;
                end
            end
            B_SHRD: begin
                if (w_next < r_count) begin
                    n_state = B_SHWR;
                end else if (w_can) begin
                    n_count   = r_count - CW'(1);
                    n_ovalid  = 1'b1;
                    n_okind   = ptt_pkg::KIND_STATUS;
                    n_ostatus = ptt_pkg::ST_OK;
                    n_oid     = '0;
                    n_olast   = 1'b1;
                    n_state   = B_IDLE;
                end
            end
            B_SHWR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_idx   = w_next;
                n_state = B_SHRD;
            end
            B_TRD: begin
                if (r_idx < r_count) begin
                    n_state = B_TCHK;
                end else if (!r_pend) begin
                    n_state = B_IDLE;
                end else if (w_can) begin
                    n_ovalid  = 1'b1;
                    n_okind   = ptt_pkg::KIND_FIRED;
                    n_ostatus = ptt_pkg::ST_OK;
                    n_oid     = r_pend_id;
                    n_olast   = 1'b1;
                    n_pend    = 1'b0;
                    n_state   = B_IDLE;
                end
            end
            B_TCHK: begin
                // A fire is held back one entry so the final one can carry last.
                if (!(w_ph >= w_rdata.period && r_pend && !w_can)) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                    n_idx   = w_next;
                    n_state = B_TRD;
                    if (w_ph >= w_rdata.period) begin
                        w_wdata.phase = '0;
                        if (r_pend) begin
                            n_ovalid  = 1'b1;
                            n_okind   = ptt_pkg::KIND_FIRED;
                            n_ostatus = ptt_pkg::ST_OK;
                            n_oid     = r_pend_id;
                            n_olast   = 1'b0;
                        end
                        n_pend    = 1'b1;
                        n_pend_id = w_rdata.id;
                    end else begin
                        w_wdata.phase = w_ph;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_pend_id <= n_pend_id;
        r_okind   <= n_okind;
        r_ostatus <= n_ostatus;
        r_oid     <= n_oid;
        r_olast   <= n_olast;
    end

    assign o_valid  = r_ovalid;
    assign o_kind   = r_okind;
    assign o_status = r_ostatus;
    assign o_id     = r_oid;
    assign o_last   = r_olast;
endmodule

/* tb/ptt_checker.sv */
// Checker for the periodic timer table: predicts results and compares them.
module ptt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic                         kind;
        logic [1:0]                   status;
        logic [ptt_pkg::IdWidth-1:0]  fired_id;
        logic                         last;
    } t_result;

    t_result                          expected_results[$];
    logic [ptt_pkg::IdWidth-1:0]      tbl_id[ptt_pkg::MaxTimers];
    logic [ptt_pkg::IvlWidth-1:0]     tbl_period[ptt_pkg::MaxTimers];
    logic [ptt_pkg::IvlWidth-1:0]     tbl_phase[ptt_pkg::MaxTimers];
    int                               tbl_count;
    logic [ptt_pkg::PulseWidth-1:0]   pulse_len;

    assign o_pending = expected_results.size();

    function automatic t_result status_result(logic [1:0] st);
        t_result r;
        r.kind = ptt_pkg::KIND_STATUS;
        r.status = st;
        r.fired_id = '0;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_expected(t_result r);
        expected_results = {expected_results, r};
    endfunction

    task automatic predict_request(logic [1:0] op, logic [ptt_pkg::IdWidth-1:0] id,
                                   logic [ptt_pkg::IvlWidth-1:0] ivl);
        int pos;
        int fired;
        logic [ptt_pkg::IvlWidth-1:0] per;
        logic [ptt_pkg::IvlWidth-1:0] ph;
        t_result r;
        pos = -1;
        fired = 0;
        for (int i = 0; i < tbl_count; i++)
            if (pos < 0 && tbl_id[i] == id) pos = i;
        case (op)
            ptt_pkg::OP_SET: begin
                per = ivl / ((pulse_len == 0) ? 1 : pulse_len);
                if (per == 0) per = 1;
                if (pos >= 0) begin
                    tbl_period[pos] = per;
                    tbl_phase[pos] = '0;
                    add_expected(status_result(ptt_pkg::ST_OK));
                end else if (tbl_count < ptt_pkg::MaxTimers) begin
                    tbl_id[tbl_count] = id;
                    tbl_period[tbl_count] = per;
                    tbl_phase[tbl_count] = '0;
                    tbl_count++;
                    add_expected(status_result(ptt_pkg::ST_OK));
                end else begin
                    add_expected(status_result(ptt_pkg::ST_FULL));
                end
            end
            ptt_pkg::OP_KILL: begin
                if (pos < 0) begin
                    add_expected(status_result(ptt_pkg::ST_NOT_FOUND));
                end else begin
                    for (int i = pos; i + 1 < tbl_count; i++) begin
                        tbl_id[i] = tbl_id[i+1];
                        tbl_period[i] = tbl_period[i+1];
                        tbl_phase[i] = tbl_phase[i+1];
                    end
                    tbl_count--;
                    add_expected(status_result(ptt_pkg::ST_OK));
                end
            end
            ptt_pkg::OP_TICK: begin
                for (int i = 0; i < tbl_count; i++) begin
                    ph = tbl_phase[i] + 1'b1;
                    if (ph >= tbl_period[i]) begin
                        tbl_phase[i] = '0;
                        r.kind = ptt_pkg::KIND_FIRED;
                        r.status = ptt_pkg::ST_OK;
                        r.fired_id = tbl_id[i];
                        r.last = 1'b0;
                        add_expected(r);
                        fired++;
                    end else begin
                        tbl_phase[i] = ph;
                    end
                end
                if (fired > 0) expected_results[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            tbl_count = 0;
            pulse_len = ptt_pkg::PulseReset;
            o_fail_count <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) pulse_len = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[55:32]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d status %0d id %h",
                           m_axis_tuser[0], m_axis_tdata[1:0], m_axis_tdata[33:2]);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.kind !== m_axis_tuser[0] || want.status !== m_axis_tdata[1:0]
                        || want.fired_id !== m_axis_tdata[33:2]
                        || want.last !== m_axis_tlast) begin
                        if (want.kind !== m_axis_tuser[0])
                            $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser[0]);
                        if (want.status !== m_axis_tdata[1:0])
                            $error("status: expected %0d, got %0d", want.status,
                                   m_axis_tdata[1:0]);
                        if (want.fired_id !== m_axis_tdata[33:2])
                            $error("fired_id: expected %h, got %h", want.fired_id,
                                   m_axis_tdata[33:2]);
                        if (want.last !== m_axis_tlast)
                            $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_periodic_timer_table_top.sv */
// Testbench top for the periodic timer table: stimulus, stalls and verdict.
module tb_periodic_timer_table_top;

    localparam logic [1:0] OpUnused = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [9:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    logic        hold_off;
    logic [ptt_pkg::IdWidth-1:0] id_pool[8];

    periodic_timer_table_top u_top (.*);

    ptt_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall pattern, fully open stretches, and one long hold-off.
    initial begin
        int mode;
        m_axis_tready = 1'b0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) m_axis_tready <= 1'b0;
            else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [ptt_pkg::IdWidth-1:0] id,
                                logic [ptt_pkg::IvlWidth-1:0] ivl);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {ivl, id};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge i_clk);
    endtask

    task automatic drain_and_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // Ticks that fire nothing may still sit in the queue or walk the table.
        repeat (4 * (ptt_pkg::MaxTimers * 2 + 4) + 40) @(posedge i_clk);
    endtask

    task automatic write_pulse(logic [9:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_request();
        int sel;
        logic [ptt_pkg::IdWidth-1:0] id;
        logic [ptt_pkg::IvlWidth-1:0] ivl;
        sel = $urandom_range(0, 99);
        id = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 7)];
        case ($urandom_range(0, 3))
            0: ivl = $urandom_range(0, 16777215);
            default: ivl = $urandom_range(0, 60);
        endcase
        if (sel < 30) send_request(ptt_pkg::OP_SET, id, ivl);
        else if (sel < 45) send_request(ptt_pkg::OP_KILL, id, ivl);
        else if (sel < 97) send_request(ptt_pkg::OP_TICK, $urandom(), $urandom());
        else send_request(OpUnused, $urandom(), $urandom());
    endtask

    initial begin
        logic [9:0] pulses[5];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ptt_pkg::OP_TICK;
        hold_off = 1'b0;
        pulses = '{10'd1, 10'd1023, 10'd0, 10'd3, 10'd1000};
        for (int i = 0; i < 8; i++) id_pool[i] = $urandom();
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, full table, absent kill, unused op.
        send_request(ptt_pkg::OP_KILL, 32'h0, 24'h0);
        send_request(ptt_pkg::OP_SET, 32'h0, 24'h0);
        send_request(ptt_pkg::OP_SET, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_request(ptt_pkg::OP_TICK, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_request(OpUnused, 32'hFFFF_FFFF, 24'hFF_FFFF);
        for (int i = 0; i < 15; i++) send_request(ptt_pkg::OP_SET, 32'h100 + i, 24'd20 + i);
        send_request(ptt_pkg::OP_SET, 32'h0, 24'd25);
        send_request(ptt_pkg::OP_TICK, '0, '0);
        send_request(ptt_pkg::OP_KILL, 32'h105, '0);
        send_request(ptt_pkg::OP_KILL, 32'h105, '0);
        drain_and_idle();

        for (int p = 0; p < 5; p++) begin
            write_pulse(pulses[p]);
            for (int n = 0; n < 60; n++) begin
                if (p == 1 && n == 10) begin
                    // Long receiver hold-off while requests keep coming.
                    hold_off <= 1'b1;
                    fork
                        begin
                            repeat (400) @(posedge i_clk);
                            hold_off <= 1'b0;
                        end
                    join_none
                    repeat (12) random_request();
                end
                if ($urandom_range(0, 5) == 0) pause_sender();
                random_request();
            end
            drain_and_idle();
        end

        drain_and_idle();
        if (fail_count == 0) $display("tb_periodic_timer_table_top: PASS");
        else $display("tb_periodic_timer_table_top: FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_periodic_timer_table_top: FAIL");
        $finish;
    end

endmodule
